@@ hdl/first_fit_bin_packer_unit_macros.svh @@
// Assertion macros used by the first-fit bin packer RTL.
`ifndef FIRST_FIT_BIN_PACKER_UNIT_MACROS_SVH
`define FIRST_FIT_BIN_PACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define FFBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ffbp assertion failed");

// Next-cycle implication, checked while reset is released.
`define FFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ffbp assertion failed");

`endif

@@ hdl/ffbp_pkg.sv @@
// Shared types and constants for the first-fit bin packer.
`timescale 1ns / 1ps

package ffbp_pkg;

    localparam int IDX_W = 6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic valid;
        logic clear;
        logic placed;
        logic opened;
    } tok_ctrl_t;

endpackage

@@ hdl/ffbp_cell.sv @@
// One bin of the packer chain: holds the bin state and forwards the word in flight.
`timescale 1ns / 1ps

module ffbp_cell #(
    parameter int SIZE_WIDTH = 24,
    parameter int CELL_IDX   = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [SIZE_WIDTH-1:0]             cap,
    input  ffbp_pkg::tok_ctrl_t               ctrl_in,
    input  logic [SIZE_WIDTH-1:0]             size_in,
    input  logic [ffbp_pkg::IDX_W-1:0]        idx_in,
    input  logic signed [SIZE_WIDTH:0]        rem_in,
    output ffbp_pkg::tok_ctrl_t               ctrl_out,
    output logic [SIZE_WIDTH-1:0]             size_out,
    output logic [ffbp_pkg::IDX_W-1:0]        idx_out,
    output logic signed [SIZE_WIDTH:0]        rem_out
);

    localparam logic [ffbp_pkg::IDX_W-1:0] MY_IDX = CELL_IDX[ffbp_pkg::IDX_W-1:0];

    logic                           open_reg,  open_next;
    logic signed [SIZE_WIDTH:0]     bin_reg,   bin_next;
    ffbp_pkg::tok_ctrl_t            ctrl_reg,  ctrl_next;
    logic [SIZE_WIDTH-1:0]          size_reg;
    logic [ffbp_pkg::IDX_W-1:0]     idx_reg,   idx_next;
    logic signed [SIZE_WIDTH:0]     rem_reg,   rem_next;

    logic signed [SIZE_WIDTH:0]     size_ext;
    logic signed [SIZE_WIDTH:0]     cap_ext;
    logic signed [SIZE_WIDTH:0]     bin_less;
    logic signed [SIZE_WIDTH:0]     cap_less;
    logic                           fits;

    assign size_ext = signed'({1'b0, size_in});
    assign cap_ext  = signed'({1'b0, cap});
    assign bin_less = bin_reg - size_ext;
    assign cap_less = cap_ext - size_ext;
    assign fits     = open_reg && (bin_reg >= size_ext);

    always_comb begin
        open_next = open_reg;
        bin_next  = bin_reg;
        ctrl_next = ctrl_in;
        idx_next  = idx_in;
        rem_next  = rem_in;
        if (ctrl_in.valid) begin
            if (ctrl_in.clear) begin
                open_next = 1'b0;
            end else if (!ctrl_in.placed) begin
                if (fits) begin
                    bin_next         = bin_less;
                    ctrl_next.placed = 1'b1;
                    idx_next         = MY_IDX;
                    rem_next         = bin_less;
                end else if (!open_reg) begin
                    open_next        = 1'b1;
                    bin_next         = cap_less;
                    ctrl_next.placed = 1'b1;
                    ctrl_next.opened = 1'b1;
                    idx_next         = MY_IDX;
                    rem_next         = cap_less;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg       <= 1'b0;
            ctrl_reg.valid <= 1'b0;
        end else begin
            open_reg       <= open_next;
            ctrl_reg.valid <= ctrl_next.valid;
        end
        bin_reg         <= bin_next;
        ctrl_reg.clear  <= ctrl_next.clear;
        ctrl_reg.placed <= ctrl_next.placed;
        ctrl_reg.opened <= ctrl_next.opened;
        size_reg        <= size_in;
        idx_reg         <= idx_next;
        rem_reg         <= rem_next;
    end

    assign ctrl_out = ctrl_reg;
    assign size_out = size_reg;
    assign idx_out  = idx_reg;
    assign rem_out  = rem_reg;

endmodule

@@ hdl/first_fit_bin_packer_unit.sv @@
// An accepted word passes the input register, the cell chain and the output register
// before its result word shows on m_tvalid. One word is held at a time; the next word
// can be taken the cycle after the result is taken.
// Reset (aresetn low, synchronous) closes every bin, empties the chain and output,
// and sets the bin capacity to 16777215.
`timescale 1ns / 1ps
`include "first_fit_bin_packer_unit_macros.svh"

module first_fit_bin_packer_unit #(
    parameter int MAX_BINS   = 64,
    parameter int SIZE_WIDTH = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [SIZE_WIDTH-1:0] cfg_wdata,   // bin_capacity
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((SIZE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,     // item_size
    input  logic [0:0]            s_tuser,     // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((ffbp_pkg::IDX_W + SIZE_WIDTH + 1 + 7) / 8) * 8 - 1:0] m_tdata,
                                               // bin_index, remaining_after
    output logic [1:0]            m_tuser      // opened_new, overflow
);

    localparam logic [SIZE_WIDTH-1:0] CAP_RESET = SIZE_WIDTH'(24'hFFFFFF);

    logic [SIZE_WIDTH-1:0]          cap_reg;
    logic                           busy_reg;
    ffbp_pkg::tok_ctrl_t            in_ctrl_reg;
    logic [SIZE_WIDTH-1:0]          in_size_reg;

    logic                           m_valid_reg;
    logic [ffbp_pkg::IDX_W-1:0]     m_idx_reg;
    logic signed [SIZE_WIDTH:0]     m_rem_reg;
    logic                           m_opened_reg;
    logic                           m_ovf_reg;

    ffbp_pkg::tok_ctrl_t            ctrl_w [0:MAX_BINS];
    logic [SIZE_WIDTH-1:0]          size_w [0:MAX_BINS];
    logic [ffbp_pkg::IDX_W-1:0]     idx_w  [0:MAX_BINS];
    logic signed [SIZE_WIDTH:0]     rem_w  [0:MAX_BINS];
    logic [MAX_BINS:0]              tok_valid;

    logic                           s_fire;
    logic                           m_fire;
    ffbp_pkg::tok_ctrl_t            tail;

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_valid_reg && m_tready;
    assign tail     = ctrl_w[MAX_BINS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wen) begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg          <= 1'b0;
            in_ctrl_reg.valid <= 1'b0;
        end else begin
            in_ctrl_reg.valid <= s_fire;
            if (s_fire) begin
                busy_reg <= 1'b1;
            end else if (m_fire) begin
                busy_reg <= 1'b0;
            end
        end
        in_ctrl_reg.clear  <= (s_tuser[0] == ffbp_pkg::OP_CLEAR);
        in_ctrl_reg.placed <= 1'b0;
        in_ctrl_reg.opened <= 1'b0;
        in_size_reg        <= s_tdata[SIZE_WIDTH-1:0];
    end

    assign ctrl_w[0] = in_ctrl_reg;
    assign size_w[0] = in_size_reg;
    assign idx_w[0]  = '0;
    assign rem_w[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_BINS; g++) begin : g_cell
            ffbp_cell #(
                .SIZE_WIDTH (SIZE_WIDTH),
                .CELL_IDX   (g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cap      (cap_reg),
                .ctrl_in  (ctrl_w[g]),
                .size_in  (size_w[g]),
                .idx_in   (idx_w[g]),
                .rem_in   (rem_w[g]),
                .ctrl_out (ctrl_w[g+1]),
                .size_out (size_w[g+1]),
                .idx_out  (idx_w[g+1]),
                .rem_out  (rem_w[g+1])
            );
        end
        for (g = 0; g <= MAX_BINS; g++) begin : g_vld
            assign tok_valid[g] = ctrl_w[g].valid;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tail.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tail.valid) begin
            m_idx_reg    <= idx_w[MAX_BINS];
            m_rem_reg    <= rem_w[MAX_BINS];
            m_opened_reg <= tail.opened;
            m_ovf_reg    <= !tail.clear && !tail.placed;
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[ffbp_pkg::IDX_W-1:0] = m_idx_reg;
        m_tdata[ffbp_pkg::IDX_W+SIZE_WIDTH:ffbp_pkg::IDX_W] = m_rem_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {m_ovf_reg, m_opened_reg};

    `FFBP_ASSERT_NOW(a_single_word, aclk, aresetn, 1'b1, $onehot0(tok_valid))
    `FFBP_ASSERT_NOW(a_out_busy, aclk, aresetn, m_valid_reg, busy_reg)
    `FFBP_ASSERT_NOW(a_tail_out_free, aclk, aresetn, tail.valid, !m_valid_reg)
    `FFBP_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_fire, busy_reg && in_ctrl_reg.valid)

endmodule

@@ tb/sv/tb_first_fit_bin_packer_unit.sv @@
// Self-checking testbench for the first-fit bin packer: directed and random words, scoreboard.
`timescale 1ns / 1ps

module tb_first_fit_bin_packer_unit;

    localparam int NUM_BINS  = 64;
    localparam int SIZE_W    = 24;
    localparam int SETTLE    = NUM_BINS + 8;
    localparam int LONG_HOLD = 500;
    localparam int IDLE_LIMIT = 3000;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    typedef struct packed {
        logic [5:0]         bin_index;
        logic               opened_new;
        logic               overflow;
        logic signed [24:0] remaining_after;
    } placement_t;

    class bin_pack_scoreboard;
        logic signed [24:0] bin_left [NUM_BINS];
        int unsigned        bins_used;
        logic [SIZE_W-1:0]  capacity;
        placement_t         placement_q [$];
        int unsigned        mismatches;

        function new();
            bins_used  = 0;
            capacity   = SIZE_MAX;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [SIZE_W-1:0] cap);
            capacity = cap;
        endfunction

        function void note_word(logic op, logic [SIZE_W-1:0] size);
            placement_t         p;
            logic signed [24:0] need;
            int unsigned        b;
            p = '0;
            need = {1'b0, size};
            if (op == ffbp_pkg::OP_CLEAR) begin
                bins_used = 0;
            end else begin
                b = 0;
                while (b < bins_used && bin_left[b] < need) b++;
                if (b < bins_used) begin
                    bin_left[b] = bin_left[b] - need;
                    p.bin_index = b[5:0];
                    p.remaining_after = bin_left[b];
                end else if (bins_used >= NUM_BINS) begin
                    p.overflow = 1'b1;
                end else begin
                    bin_left[b] = $signed({1'b0, capacity}) - need;
                    bins_used++;
                    p.bin_index = b[5:0];
                    p.opened_new = 1'b1;
                    p.remaining_after = bin_left[b];
                end
            end
            placement_q.push_back(p);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_word(logic [31:0] tdata, logic [1:0] tuser);
            placement_t e;
            placement_t g;
            g.bin_index       = tdata[5:0];
            g.remaining_after = tdata[30:6];
            g.opened_new      = tuser[0];
            g.overflow        = tuser[1];
            if (placement_q.size() == 0) begin
                report("unexpected word, bin_index", g.bin_index, 0);
                return;
            end
            e = placement_q.pop_front();
            if (g.bin_index !== e.bin_index) report("bin_index", g.bin_index, e.bin_index);
            if (g.opened_new !== e.opened_new) report("opened_new", g.opened_new, e.opened_new);
            if (g.overflow !== e.overflow) report("overflow", g.overflow, e.overflow);
            if (g.remaining_after !== e.remaining_after)
                report("remaining_after", g.remaining_after, e.remaining_after);
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wen;
    logic [SIZE_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;   // item_size
    logic [0:0]        s_tuser;   // op
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // bin_index, remaining_after
    logic [1:0]        m_tuser;   // opened_new, overflow

    bin_pack_scoreboard sb = new();

    int          src_gap_pct = 30;
    int          sink_stall_pct = 30;
    int unsigned words_out = 0;
    int unsigned idle_cycles = 0;

    always #6 aclk = ~aclk;

    first_fit_bin_packer_unit #(
        .MAX_BINS   (NUM_BINS),
        .SIZE_WIDTH (SIZE_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && s_tready) sb.note_word(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata, m_tuser);
                words_out++;
            end
        end
    end

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 7) == 0) return $urandom_range(15, 70);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(logic [SIZE_W-1:0] cap, bit fill);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (fill && $urandom_range(0, 99) < 85) r = 30;
        if (r < 10) return '0;
        if (r < 20) return cap;
        if (r < 55) return SIZE_W'($urandom_range(cap, cap / 2 + 1));
        if (r < 75) return SIZE_W'($urandom_range(cap / 4, 0));
        if (r < 90) return SIZE_W'($urandom());
        if (cap == SIZE_MAX) return SIZE_MAX;
        return SIZE_W'($urandom_range(SIZE_MAX, cap + 1));
    endfunction

    // The sink stalls at random, and once holds off long enough to back up the input.
    initial begin
        int  stall;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!long_hold_done && words_out >= 150) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                stall = pick_gap(sink_stall_pct);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end else begin
                    m_tready <= 1'b1;
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    task push_word(input logic op, input logic [SIZE_W-1:0] size);
        int gap;
        gap = pick_gap(src_gap_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= size;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task wait_all_placed();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.placement_q.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task write_capacity(input logic [SIZE_W-1:0] cap);
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        sb.set_capacity(cap);
    endtask

    task run_phase(input logic [SIZE_W-1:0] cap, input int count, input bit fill,
                   input int gap_pct, input int stall_pct);
        logic op;
        wait_all_placed();
        write_capacity(cap);
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            op = (!fill && $urandom_range(0, 99) < 3) ? ffbp_pkg::OP_CLEAR
                                                       : ffbp_pkg::OP_INSERT;
            push_word(op, pick_size(cap, fill));
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ffbp_pkg::OP_INSERT;
        m_tready  <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset capacity: exact fill, zero-size words, a clear and alternating bit patterns.
        push_word(ffbp_pkg::OP_INSERT, '0);
        push_word(ffbp_pkg::OP_INSERT, SIZE_MAX);
        push_word(ffbp_pkg::OP_INSERT, '0);
        push_word(ffbp_pkg::OP_INSERT, 24'd1);
        push_word(ffbp_pkg::OP_INSERT, 24'h800000);
        push_word(ffbp_pkg::OP_CLEAR, 24'h123456);
        push_word(ffbp_pkg::OP_INSERT, 24'h555555);
        push_word(ffbp_pkg::OP_INSERT, 24'hAAAAAA);
        push_word(ffbp_pkg::OP_INSERT, 24'hAAAAAA);

        // Zero capacity: every nonzero word is oversize and leaves a negative bin.
        wait_all_placed();
        write_capacity('0);
        push_word(ffbp_pkg::OP_CLEAR, '0);
        push_word(ffbp_pkg::OP_INSERT, SIZE_MAX);
        push_word(ffbp_pkg::OP_INSERT, '0);
        push_word(ffbp_pkg::OP_INSERT, '0);
        push_word(ffbp_pkg::OP_INSERT, 24'd1);
        push_word(ffbp_pkg::OP_CLEAR, SIZE_MAX);
        push_word(ffbp_pkg::OP_CLEAR, '0);

        wait_all_placed();
        write_capacity(24'd1);
        push_word(ffbp_pkg::OP_INSERT, 24'd1);
        push_word(ffbp_pkg::OP_INSERT, 24'd2);
        push_word(ffbp_pkg::OP_INSERT, '0);
        push_word(ffbp_pkg::OP_INSERT, SIZE_MAX);

        run_phase(SIZE_MAX, 45, 1'b0, 30, 30);
        run_phase(SIZE_W'($urandom_range(4000, 200)), 90, 1'b1, 0, 0);
        run_phase('0, 45, 1'b0, 50, 40);
        run_phase(24'd1, 45, 1'b0, 20, 20);
        run_phase(SIZE_W'($urandom_range(SIZE_MAX, 0)), 45, 1'b0, 30, 30);
        run_phase(SIZE_MAX, 90, 1'b1, 25, 25);
        run_phase(24'd100, 45, 1'b0, 30, 50);
        run_phase(SIZE_W'($urandom_range(SIZE_MAX, 0)), 45, 1'b0, 10, 10);

        wait_all_placed();
        if (sb.mismatches == 0 && sb.placement_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ first_fit_bin_packer_unit.f @@
+incdir+hdl
hdl/ffbp_pkg.sv
hdl/ffbp_cell.sv
hdl/first_fit_bin_packer_unit.sv
tb/sv/tb_first_fit_bin_packer_unit.sv
